### rtl/core/jbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON byte tokenizer package
// Shared types, token codes, character constants and result queue sizing.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);
  localparam int unsigned ResIdxW  = $clog2(ResDepth);
  localparam int unsigned SkipW    = 3;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChRBrack  = 8'h5D;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChF       = 8'h66;
  localparam logic [7:0] ChT       = 8'h74;
  localparam logic [7:0] ChN       = 8'h6E;

  localparam logic [SkipW-1:0] SkipFalse = 3'd4;
  localparam logic [SkipW-1:0] SkipOther = 3'd3;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeStr  = 2'd1,
    ModeNum  = 2'd2,
    ModeSkip = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    KindString  = 4'd0,
    KindNumber  = 4'd1,
    KindBool    = 4'd2,
    KindNull    = 4'd3,
    KindCOpen   = 4'd4,
    KindCClose  = 4'd5,
    KindAOpen   = 4'd6,
    KindAClose  = 4'd7,
    KindColon   = 4'd8,
    KindComma   = 4'd9,
    KindUnknown = 4'd10
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value_char;
    logic       char_present;
    logic       token_complete;
    logic       bool_true;
    logic       truncated;
    logic       final_result;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } lex_out_t;

endpackage

### rtl/core/jbt_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON tokenizer lexer
// Holds the lexing mode and skip count, and turns one byte into up to two
// results.
// ----------------------------------------------------------------------------
module jbt_lexer import jbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  output lex_out_t   lex_o
);

  mode_e            mode_q, mode_d;
  logic [SkipW-1:0] skip_q, skip_d;

  logic             il_valid;
  res_t             il_res;
  mode_e            il_mode;
  logic [SkipW-1:0] il_skip;
  logic             num_char;

  assign num_char = (byte_i == ChMinus) || (byte_i == ChDot) ||
                    ((byte_i >= ChZero) && (byte_i <= ChNine));

  always_comb begin
    il_valid = 1'b1;
    il_res   = '0;
    il_mode  = ModeIdle;
    il_skip  = skip_q;
    il_res.token_complete = 1'b1;
    priority if ((byte_i == ChSpace) || (byte_i == ChNewline)) begin
      il_valid = 1'b0;
    end else if (byte_i == ChQuote) begin
      il_mode = ModeStr;
      il_valid = eot_i;
      il_res.kind = KindString;
      il_res.truncated = 1'b1;
    end else if ((byte_i == ChMinus) || ((byte_i >= ChZero) && (byte_i <= ChNine))) begin
      il_mode = ModeNum;
      il_res.kind = KindNumber;
      il_res.value_char = byte_i;
      il_res.char_present = 1'b1;
      il_res.token_complete = eot_i;
    end else if ((byte_i == ChF) || (byte_i == ChT) || (byte_i == ChN)) begin
      il_mode = ModeSkip;
      il_skip = (byte_i == ChF) ? SkipFalse : SkipOther;
      il_res.kind = (byte_i == ChN) ? KindNull : KindBool;
      il_res.bool_true = (byte_i == ChT);
      il_res.truncated = eot_i;
    end else begin
      unique case (byte_i)
        ChLBrace: il_res.kind = KindCOpen;
        ChRBrace: il_res.kind = KindCClose;
        ChLBrack: il_res.kind = KindAOpen;
        ChRBrack: il_res.kind = KindAClose;
        ChColon:  il_res.kind = KindColon;
        ChComma:  il_res.kind = KindComma;
        default:  il_res.kind = KindUnknown;
      endcase
    end
  end

  always_comb begin
    lex_o  = '0;
    mode_d = mode_q;
    skip_d = skip_q;
    unique case (mode_q)
      ModeIdle: begin
        lex_o.cnt  = {1'b0, il_valid};
        lex_o.res0 = il_res;
        mode_d     = il_mode;
        skip_d     = il_skip;
      end
      ModeStr: begin
        lex_o.cnt = 2'd1;
        lex_o.res0.kind = KindString;
        lex_o.res0.token_complete = 1'b1;
        if (byte_i == ChQuote) begin
          mode_d = ModeIdle;
        end else begin
          lex_o.res0.value_char = byte_i;
          lex_o.res0.char_present = 1'b1;
          lex_o.res0.token_complete = eot_i;
          lex_o.res0.truncated = eot_i;
        end
      end
      ModeNum: begin
        lex_o.res0.kind = KindNumber;
        lex_o.res0.token_complete = 1'b1;
        if (num_char) begin
          lex_o.cnt = 2'd1;
          lex_o.res0.value_char = byte_i;
          lex_o.res0.char_present = 1'b1;
          lex_o.res0.token_complete = eot_i;
        end else begin
          lex_o.cnt  = il_valid ? 2'd2 : 2'd1;
          lex_o.res1 = il_res;
          mode_d     = il_mode;
          skip_d     = il_skip;
        end
      end
      ModeSkip: begin
        skip_d = skip_q - 3'd1;
        if (skip_d == '0) begin
          mode_d = ModeIdle;
        end else if (eot_i) begin
          lex_o.cnt = 2'd1;
          lex_o.res0.kind = KindUnknown;
          lex_o.res0.token_complete = 1'b1;
          lex_o.res0.truncated = 1'b1;
        end
      end
      default: begin
        mode_d = ModeIdle;
      end
    endcase
    if (eot_i) begin
      mode_d = ModeIdle;
      skip_d = '0;
    end
    if (lex_o.cnt == 2'd1) begin
      lex_o.res0.final_result = 1'b1;
    end
    if (lex_o.cnt == 2'd2) begin
      lex_o.res1.final_result = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      skip_q <= '0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      skip_q <= skip_d;
    end
  end

  // The skip count is non-zero exactly while literal bytes are being skipped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeSkip) == (skip_q != '0))
    else $error("skip count out of step with lexing mode");

  // Only a number closed by another byte can give two results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lex_o.cnt == 2'd2) |-> (mode_q == ModeNum))
    else $error("two results outside number mode");

  // A first result either carries a byte or ends its token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && (lex_o.cnt != 2'd0)) |->
      (lex_o.res0.char_present || lex_o.res0.token_complete))
    else $error("result with neither a byte nor a token end");

endmodule

### rtl/core/jbt_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON tokenizer result queue
// Shifting queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module jbt_result_fifo import jbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] wr_cnt_i,
  input  res_t       wr0_i,
  input  res_t       wr1_i,
  input  logic       pop_i,
  output logic       valid_o,
  output logic       room_o,
  output res_t       head_o
);

  res_t               entries_q [ResDepth];
  res_t               entries_d [ResDepth];
  logic [ResCntW-1:0] count_q, count_d;
  logic [ResCntW-1:0] base;

  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= ResCntW'(ResDepth - 2));
  assign head_o  = entries_q[0];
  assign base    = count_q - ResCntW'(pop_i);

  always_comb begin
    entries_d = entries_q;
    if (pop_i) begin
      for (int i = 0; i < ResDepth - 1; i++) begin
        entries_d[i] = entries_q[i + 1];
      end
    end
    if (wr_cnt_i != 2'd0) begin
      entries_d[base[ResIdxW-1:0]] = wr0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      entries_d[ResIdxW'(base + ResCntW'(1))] = wr1_i;
    end
    count_d = base + ResCntW'(wr_cnt_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ResCntW'(ResDepth))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_cnt_i != 2'd0) |-> room_o)
    else $error("result written without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("result taken from an empty queue");

endmodule

### rtl/core/json_byte_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON byte tokenizer
// Lexes a JSON text arriving one byte per item into a stream of token results.
// ----------------------------------------------------------------------------
// One input item is accepted per clock cycle while the result queue has room. An
// accepted byte waits in the input register, where the lexer classifies it,
// and its results are then written into the result queue, whose head drives
// the output. Most bytes give at most one result; a byte that closes a number
// and then starts a token of its own gives two, and the output port, which
// delivers one result per cycle unless stalled, sets the sustained rate in that
// case. A four-entry result queue absorbs these bursts, and input items are held
// off only while it has fewer than two free entries.
module json_byte_tokenizer import jbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] token_kind_o,
  output logic [7:0] value_char_o,
  output logic       char_present_o,
  output logic       token_complete_o,
  output logic       bool_true_o,
  output logic       truncated_o,
  output logic       final_result_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic       room;
  logic       advance;
  logic       pop;
  lex_out_t   lex;
  res_t       head;

  assign advance    = in_vld_q && room;
  assign in_stall_o = in_vld_q && !room;
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  jbt_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (in_byte_q),
    .eot_i     (in_eot_q),
    .lex_o     (lex)
  );

  jbt_result_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_cnt_i (advance ? lex.cnt : 2'd0),
    .wr0_i    (lex.res0),
    .wr1_i    (lex.res1),
    .pop_i    (pop),
    .valid_o  (out_valid_o),
    .room_o   (room),
    .head_o   (head)
  );

  assign token_kind_o     = head.kind;
  assign value_char_o     = head.value_char;
  assign char_present_o   = head.char_present;
  assign token_complete_o = head.token_complete;
  assign bool_true_o      = head.bool_true;
  assign truncated_o      = head.truncated;
  assign final_result_o   = head.final_result;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON byte tokenizer testbench
// Drives JSON texts and random noise into the tokenizer, one byte per item,
// with random gaps on the input and random stalls on the output. Its own
// lexer predicts the token results of every accepted byte, and each result
// that the block delivers is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import jbt_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomItems = 1600;
  localparam int unsigned MaxWait     = 12;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned DrainCycles = 8;

  localparam logic [7:0] Punctuation [6] = '{
    ChLBrace, ChRBrace, ChLBrack, ChRBrack, ChColon, ChComma
  };

  localparam logic [8:0] DirectedText [26] = '{
    {ChLBrace, 1'b0}, {ChQuote, 1'b0}, {ChQuote, 1'b0}, {ChColon, 1'b0},
    {ChMinus, 1'b0}, {ChDot, 1'b0}, {ChNine, 1'b0}, {ChQuote, 1'b0},
    {8'h62, 1'b1},
    {ChLBrack, 1'b0}, {ChZero, 1'b0}, {ChRBrack, 1'b0}, {ChSpace, 1'b0},
    {ChNewline, 1'b0}, {ChT, 1'b0}, {8'h00, 1'b0}, {8'hFF, 1'b0},
    {ChQuote, 1'b0}, {ChComma, 1'b0}, {ChF, 1'b0}, {8'h78, 1'b1},
    {ChRBrace, 1'b0}, {ChN, 1'b1}, {ChQuote, 1'b1}, {8'h5A, 1'b0},
    {ChNine, 1'b1}
  };

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i        = 8'h00;
  logic       end_of_text_i    = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic [3:0] token_kind_o;
  logic [7:0] value_char_o;
  logic       char_present_o;
  logic       token_complete_o;
  logic       bool_true_o;
  logic       truncated_o;
  logic       final_result_o;

  mode_e            lex_state   = ModeIdle;
  logic [SkipW-1:0] skip_left_q = '0;
  res_t             byte_tokens[$];
  res_t             expected_tokens[$];
  int               failures      = 0;
  int               counted_items = 0;
  int               cycle_count   = 0;
  logic             no_idle       = 1'b0;

  json_byte_tokenizer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .end_of_text_i    (end_of_text_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .token_kind_o     (token_kind_o),
    .value_char_o     (value_char_o),
    .char_present_o   (char_present_o),
    .token_complete_o (token_complete_o),
    .bool_true_o      (bool_true_o),
    .truncated_o      (truncated_o),
    .final_result_o   (final_result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic res_t make_token(kind_e kind, logic [7:0] ch, logic present,
                                      logic complete, logic is_true, logic trunc);
    res_t r;
    r.kind           = kind;
    r.value_char     = present ? ch : 8'h00;
    r.char_present   = present;
    r.token_complete = complete;
    r.bool_true      = is_true;
    r.truncated      = trunc;
    r.final_result   = 1'b0;
    return r;
  endfunction

  function automatic string format_token(res_t r);
    return $sformatf("kind %0d char %02h present %0b complete %0b true %0b trunc %0b final %0b",
                     r.kind, r.value_char, r.char_present, r.token_complete,
                     r.bool_true, r.truncated, r.final_result);
  endfunction

  function automatic void lex_between_tokens(logic [7:0] c, logic eot);
    kind_e kind;
    if (c == ChSpace || c == ChNewline) return;
    if (c == ChQuote) begin
      lex_state = ModeStr;
      if (eot) byte_tokens.push_back(make_token(KindString, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
      return;
    end
    if (c == ChMinus || (c >= ChZero && c <= ChNine)) begin
      lex_state = ModeNum;
      byte_tokens.push_back(make_token(KindNumber, c, 1'b1, eot, 1'b0, 1'b0));
      return;
    end
    if (c == ChF || c == ChT || c == ChN) begin
      skip_left_q = (c == ChF) ? SkipFalse : SkipOther;
      lex_state   = ModeSkip;
      byte_tokens.push_back(make_token((c == ChN) ? KindNull : KindBool, 8'h00, 1'b0,
                                       1'b1, c == ChT, eot));
      return;
    end
    case (c)
      ChLBrace: kind = KindCOpen;
      ChRBrace: kind = KindCClose;
      ChLBrack: kind = KindAOpen;
      ChRBrack: kind = KindAClose;
      ChColon:  kind = KindColon;
      ChComma:  kind = KindComma;
      default:  kind = KindUnknown;
    endcase
    byte_tokens.push_back(make_token(kind, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
  endfunction

  // Works out the token results of one accepted byte and queues them.
  function automatic void tokenize_byte(logic [7:0] c, logic eot);
    byte_tokens.delete();
    case (lex_state)
      ModeStr: begin
        if (c == ChQuote) begin
          lex_state = ModeIdle;
          byte_tokens.push_back(make_token(KindString, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        end else begin
          byte_tokens.push_back(make_token(KindString, c, 1'b1, eot, 1'b0, eot));
        end
      end
      ModeNum: begin
        if (c == ChMinus || c == ChDot || (c >= ChZero && c <= ChNine)) begin
          byte_tokens.push_back(make_token(KindNumber, c, 1'b1, eot, 1'b0, 1'b0));
        end else begin
          lex_state = ModeIdle;
          byte_tokens.push_back(make_token(KindNumber, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
          lex_between_tokens(c, eot);
        end
      end
      ModeSkip: begin
        skip_left_q = skip_left_q - 1'b1;
        if (skip_left_q == '0) begin
          lex_state = ModeIdle;
        end else if (eot) begin
          byte_tokens.push_back(make_token(KindUnknown, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1));
        end
      end
      default: lex_between_tokens(c, eot);
    endcase
    if (eot) begin
      lex_state   = ModeIdle;
      skip_left_q = '0;
    end
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].final_result = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  task automatic report_failure(input string what);
    failures++;
    if (failures <= ReportLimit) $display("%s", what);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxWait);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= c;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    tokenize_byte(c, eot);
    if (c != ChSpace && c != ChNewline) counted_items++;
  endtask

  task automatic wait_for_tokens();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    res_t seen;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.kind           = kind_e'(token_kind_o);
      seen.value_char     = value_char_o;
      seen.char_present   = char_present_o;
      seen.token_complete = token_complete_o;
      seen.bool_true      = bool_true_o;
      seen.truncated      = truncated_o;
      seen.final_result   = final_result_o;
      if (expected_tokens.size() == 0) begin
        report_failure({"unexpected token result: ", format_token(seen)});
      end else begin
        want = expected_tokens.pop_front();
        if (seen !== want) begin
          report_failure({"token mismatch: expected ", format_token(want),
                          ", got ", format_token(seen)});
        end
      end
    end
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, MaxWait);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic test_directed_text();
    foreach (DirectedText[i]) send_byte(DirectedText[i][8:1], DirectedText[i][0]);
    wait_for_tokens();
  endtask

  // Short bursts of JSON characters, each followed by a pause until every
  // token result of the burst has come out.
  task automatic test_pause_until_drained();
    int burst;
    for (int round = 0; round < 4; round++) begin
      burst = $urandom_range(3, 8);
      for (int i = 0; i < burst; i++) begin
        case ($urandom_range(0, 3))
          0:       send_byte(Punctuation[$urandom_range(0, 5)], 1'b0);
          1:       send_byte(ChQuote, 1'b0);
          2:       send_byte(ChZero + 8'($urandom_range(0, 9)), 1'b0);
          default: send_byte(ChT, i == burst - 1);
        endcase
      end
      wait_for_tokens();
    end
  endtask

  // Numbers closed by commas give two results per comma, so an unbroken
  // stream of them presses against the result queue.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_byte(ChZero + 8'($urandom_range(0, 9)), 1'b0);
      send_byte(ChComma, i == 39);
    end
    wait_for_tokens();
    no_idle = 1'b0;
  endtask

  task automatic test_random_texts();
    logic [7:0] text[$];
    string      lit;
    int         pieces;
    int         len;
    int         r;
    counted_items = 0;
    while (counted_items < RandomItems) begin
      no_idle = ($urandom_range(0, 4) == 0);
      text.delete();
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
        continue;
      end
      pieces = $urandom_range(1, 12);
      for (int p = 0; p < pieces; p++) begin
        case ($urandom_range(0, 9))
          1, 2: begin
            text.push_back(ChQuote);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
              r = $urandom_range(0, 255);
              text.push_back((r == ChQuote) ? 8'h61 : r[7:0]);
            end
            text.push_back(ChQuote);
          end
          3, 4: begin
            r = $urandom_range(0, 10);
            text.push_back((r == 10) ? ChMinus : ChZero + r[7:0]);
            len = $urandom_range(0, 5);
            for (int i = 0; i < len; i++) begin
              r = $urandom_range(0, 11);
              text.push_back((r == 10) ? ChDot : (r == 11) ? ChMinus : ChZero + r[7:0]);
            end
          end
          5: begin
            r = $urandom_range(0, 2);
            lit = (r == 0) ? "true" : (r == 1) ? "false" : "null";
            text.push_back(lit[0]);
            for (int i = 1; i < lit.len(); i++) begin
              text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : lit[i]);
            end
          end
          6: begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
              text.push_back($urandom_range(0, 1) ? ChSpace : ChNewline);
            end
          end
          7:       text.push_back(8'($urandom_range(0, 255)));
          default: text.push_back(Punctuation[$urandom_range(0, 5)]);
        endcase
      end
      if (text.size() > 1 && $urandom_range(0, 3) == 0) begin
        text = text[0:$urandom_range(0, text.size() - 1)];
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_text();
    test_pause_until_drained();
    test_back_to_back();
    test_random_texts();
    wait_for_tokens();
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/jbt_pkg.sv
rtl/core/jbt_lexer.sv
rtl/core/jbt_result_fifo.sv
rtl/core/json_byte_tokenizer.sv
sim/testbench.sv
